FILE: sv/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define SBC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same check, also active during reset
`define SBC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/asbc_pkg.sv
`default_nettype none
package asbc_pkg;

    localparam int TILES_DEF = 4096;

    localparam logic [1:0] CMP_X_RIGHT = 2'd0;  // tx + tw > bx
    localparam logic [1:0] CMP_X_LEFT  = 2'd1;  // tx < bx + w
    localparam logic [1:0] CMP_Y_BOT   = 2'd2;  // ty + th > by
    localparam logic [1:0] CMP_Y_TOP   = 2'd3;  // ty < by + h

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MOVE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_SUM,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [22:0] w;
        logic [22:0] h;
        logic        solid;
    } tile_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        logic  hit;
        tile_t tile;
    } pipe_t;

    typedef struct packed {
        logic [23:0] bx;
        logic [23:0] by;
        logic [25:0] bxw;
        logic [25:0] byh;
    } box_t;

    function automatic logic signed [25:0] sext26(input logic [23:0] v);
        return $signed({{2{v[23]}}, v});
    endfunction

    function automatic logic signed [25:0] zext26(input logic [22:0] v);
        return $signed({3'b000, v});
    endfunction

endpackage
`default_nettype wire

FILE: sv/axis_separated_box_collision.sv
`default_nettype none
// Tile box collision over a stream. A write transfer (tuser 0) stores one tile
// in the table and gives no result. A move transfer (tuser 1) steps the box on
// x, scans every slot through a four-cell compare chain to snap against solid
// tiles, then does the same on y, and gives one result. The single read port of
// the tile table delivers one slot a cycle. After reset the table is cleared
// slot by slot, during which no transfer is taken.
`include "assert_macros.svh"
module axis_separated_box_collision #(
    parameter int TILES = asbc_pkg::TILES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slot[11:0] box_x[35:12] box_y[59:36] box_w[82:60] box_h[105:83]
    // solid[106] step_x[123:107] step_y[140:124], zero fill to 143
    input  wire logic [143:0] s_tdata,
    // op
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // new_x[23:0] new_y[47:24] stop_x[48] stop_y[49], zero fill to 55
    output logic [55:0]       m_tdata
);

    localparam int AW = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int SW = (AW > 12) ? AW : 12;
    localparam logic [AW:0] LAST_IDX = (AW + 1)'(TILES - 1);

    asbc_pkg::tile_t mem [TILES];

    asbc_pkg::state_t state_reg, state_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic        axis_y_reg;
    logic [23:0] in_x_reg, in_y_reg, res_x_reg, res_y_reg;
    logic [22:0] w_reg, h_reg;
    logic [16:0] sx_reg, sy_reg;
    logic        stop_x_reg, stop_y_reg;
    logic        m_tvalid_reg;
    logic [49:0] m_data_reg;
    asbc_pkg::box_t box_reg;

    logic        s_xfer, do_write, issue, clearing, load_out;
    logic [SW-1:0] slot_ext;
    asbc_pkg::tile_t wr_tile, rd_tile_reg;
    logic        rd_valid_reg, rd_last_reg;
    asbc_pkg::pipe_t p0, p1, p2, p3, p4;

    assign slot_ext = SW'(s_tdata[11:0]);
    assign s_xfer   = s_tvalid && s_tready;
    assign do_write = s_xfer && (s_tuser == asbc_pkg::OP_WRITE) &&
                      ({5'b0, s_tdata[11:0]} < 17'(TILES));
    assign wr_tile  = '{x: s_tdata[35:12], y: s_tdata[59:36], w: s_tdata[82:60],
                        h: s_tdata[105:83], solid: s_tdata[106]};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asbc_pkg::ST_CLEAR: if (cnt_reg == LAST_IDX) state_next = asbc_pkg::ST_IDLE;
            asbc_pkg::ST_IDLE: begin
                if (s_xfer && s_tuser == asbc_pkg::OP_MOVE) state_next = asbc_pkg::ST_STEP;
            end
            asbc_pkg::ST_STEP: state_next = asbc_pkg::ST_SUM;
            asbc_pkg::ST_SUM:  state_next = asbc_pkg::ST_SCAN;
            asbc_pkg::ST_SCAN: begin
                if (p4.valid && p4.last)
                    state_next = axis_y_reg ? asbc_pkg::ST_OUT : asbc_pkg::ST_STEP;
            end
            asbc_pkg::ST_OUT: if (load_out) state_next = asbc_pkg::ST_IDLE;
            default: state_next = asbc_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        clearing = 1'b0;
        load_out = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            asbc_pkg::ST_CLEAR: begin
                clearing = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            asbc_pkg::ST_IDLE: s_tready = 1'b1;
            asbc_pkg::ST_SUM:  cnt_next = '0;
            asbc_pkg::ST_SCAN: begin
                issue = !cnt_reg[AW] && (cnt_reg <= LAST_IDX);
                if (issue) cnt_next = cnt_reg + 1'b1;
            end
            asbc_pkg::ST_OUT: load_out = !m_tvalid_reg || m_tready;
            default: cnt_next = '0;
        endcase
    end

    // tile table, single write and single registered read
    always_ff @(posedge aclk) begin
        if (clearing) begin
            mem[cnt_reg[AW-1:0]] <= '0;
        end else if (do_write) begin
            mem[slot_ext[AW-1:0]] <= wr_tile;
        end
        rd_tile_reg <= mem[cnt_reg[AW-1:0]];
        rd_last_reg <= (cnt_reg == LAST_IDX);
    end

    always_comb begin
        p0.valid = rd_valid_reg;
        p0.last  = rd_last_reg;
        p0.hit   = rd_tile_reg.solid;
        p0.tile  = rd_tile_reg;
    end

    asbc_cell #(.KIND(asbc_pkg::CMP_X_RIGHT)) u_cell0 (
        .aclk(aclk), .aresetn(aresetn), .box(box_reg), .pipe_in(p0), .pipe_out(p1));
    asbc_cell #(.KIND(asbc_pkg::CMP_X_LEFT)) u_cell1 (
        .aclk(aclk), .aresetn(aresetn), .box(box_reg), .pipe_in(p1), .pipe_out(p2));
    asbc_cell #(.KIND(asbc_pkg::CMP_Y_BOT)) u_cell2 (
        .aclk(aclk), .aresetn(aresetn), .box(box_reg), .pipe_in(p2), .pipe_out(p3));
    asbc_cell #(.KIND(asbc_pkg::CMP_Y_TOP)) u_cell3 (
        .aclk(aclk), .aresetn(aresetn), .box(box_reg), .pipe_in(p3), .pipe_out(p4));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= asbc_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            axis_y_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= issue;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == asbc_pkg::ST_IDLE) begin
                axis_y_reg <= 1'b0;
            end else if (state_reg == asbc_pkg::ST_SCAN && p4.valid && p4.last) begin
                axis_y_reg <= 1'b1;
            end
        end
    end

    // move datapath
    always_ff @(posedge aclk) begin
        if (state_reg == asbc_pkg::ST_IDLE && s_xfer) begin
            in_x_reg   <= s_tdata[35:12];
            in_y_reg   <= s_tdata[59:36];
            w_reg      <= s_tdata[82:60];
            h_reg      <= s_tdata[105:83];
            sx_reg     <= s_tdata[123:107];
            sy_reg     <= s_tdata[140:124];
            stop_x_reg <= 1'b0;
            stop_y_reg <= 1'b0;
        end
        if (state_reg == asbc_pkg::ST_STEP) begin
            if (axis_y_reg) begin
                box_reg.bx <= res_x_reg;
                box_reg.by <= in_y_reg + {{7{sy_reg[16]}}, sy_reg};
                res_y_reg  <= in_y_reg + {{7{sy_reg[16]}}, sy_reg};
            end else begin
                box_reg.bx <= in_x_reg + {{7{sx_reg[16]}}, sx_reg};
                box_reg.by <= in_y_reg;
                res_x_reg  <= in_x_reg + {{7{sx_reg[16]}}, sx_reg};
            end
        end
        if (state_reg == asbc_pkg::ST_SUM) begin
            box_reg.bxw <= asbc_pkg::sext26(box_reg.bx) + asbc_pkg::zext26(w_reg);
            box_reg.byh <= asbc_pkg::sext26(box_reg.by) + asbc_pkg::zext26(h_reg);
        end
        // snap on the chain output, last hit in slot order wins
        if (state_reg == asbc_pkg::ST_SCAN && p4.valid && p4.hit) begin
            if (axis_y_reg) begin
                if (sy_reg[16]) begin
                    res_y_reg  <= p4.tile.y + {1'b0, p4.tile.h};
                    stop_y_reg <= 1'b1;
                end else if (sy_reg != '0) begin
                    res_y_reg  <= p4.tile.y - {1'b0, h_reg};
                    stop_y_reg <= 1'b1;
                end
            end else begin
                if (sx_reg[16]) begin
                    res_x_reg  <= p4.tile.x + {1'b0, p4.tile.w};
                    stop_x_reg <= 1'b1;
                end else if (sx_reg != '0) begin
                    res_x_reg  <= p4.tile.x - {1'b0, w_reg};
                    stop_x_reg <= 1'b1;
                end
            end
        end
        if (load_out) begin
            m_data_reg <= {stop_y_reg, stop_x_reg, res_y_reg, res_x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

    `SBC_ASSERT(a_chain_in_scan, aclk, aresetn,
        p4.valid |-> (state_reg == asbc_pkg::ST_SCAN), "tile data outside a scan")
    `SBC_ASSERT(a_result_held, aclk, aresetn,
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg, "result dropped while stalled")
    `SBC_ASSERT(a_result_source, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == asbc_pkg::ST_OUT), "result without move")

endmodule
`default_nettype wire

FILE: sv/asbc_cell.sv
`default_nettype none
module asbc_cell #(
    parameter logic [1:0] KIND = asbc_pkg::CMP_X_RIGHT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire asbc_pkg::box_t  box,
    input  wire asbc_pkg::pipe_t pipe_in,
    output asbc_pkg::pipe_t      pipe_out
);

    logic            valid_reg;
    asbc_pkg::pipe_t data_reg, data_next;
    logic            pass;

    always_comb begin
        case (KIND)
            asbc_pkg::CMP_X_RIGHT:
                pass = (asbc_pkg::sext26(pipe_in.tile.x) + asbc_pkg::zext26(pipe_in.tile.w))
                       > asbc_pkg::sext26(box.bx);
            asbc_pkg::CMP_X_LEFT:
                pass = asbc_pkg::sext26(pipe_in.tile.x) < $signed(box.bxw);
            asbc_pkg::CMP_Y_BOT:
                pass = (asbc_pkg::sext26(pipe_in.tile.y) + asbc_pkg::zext26(pipe_in.tile.h))
                       > asbc_pkg::sext26(box.by);
            default:
                pass = asbc_pkg::sext26(pipe_in.tile.y) < $signed(box.byh);
        endcase
    end

    always_comb begin
        data_next     = pipe_in;
        data_next.hit = pipe_in.hit & pass;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= pipe_in.valid;
        end
        data_reg <= data_next;
    end

    always_comb begin
        pipe_out       = data_reg;
        pipe_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int NSLOT = asbc_pkg::TILES_DEF;

    typedef struct packed {
        logic        op;
        logic [11:0] slot;
        logic [23:0] bx;
        logic [23:0] by;
        logic [22:0] bw;
        logic [22:0] bh;
        logic        solid;
        logic [16:0] sx;
        logic [16:0] sy;
    } cmd_t;

    typedef struct packed {
        logic [23:0] nx;
        logic [23:0] ny;
        logic        stop_x;
        logic        stop_y;
    } res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;

    axis_separated_box_collision dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor's tile table
    logic signed [63:0] t_x [NSLOT];
    logic signed [63:0] t_y [NSLOT];
    logic signed [63:0] t_w [NSLOT];
    logic signed [63:0] t_h [NSLOT];
    logic               t_solid [NSLOT];

    cmd_t pending_cmds[$];
    res_t expected_moves[$];
    int   errors = 0;
    int   send_idle_pct = 20;
    int   recv_idle_pct = 85;
    logic [31:0] written_slots[$];

    function automatic logic signed [63:0] wrap24(input logic signed [63:0] v);
        logic [23:0] t;
        t = v[23:0];
        return {{40{t[23]}}, t};
    endfunction

    function automatic bit overlaps(input int i, input logic signed [63:0] x,
                                    input logic signed [63:0] y,
                                    input logic signed [63:0] w,
                                    input logic signed [63:0] h);
        return t_solid[i] && (t_x[i] + t_w[i] > x) && (t_x[i] < x + w) &&
               (t_y[i] + t_h[i] > y) && (t_y[i] < y + h);
    endfunction

    task automatic apply_cmd(input cmd_t c);
        logic signed [63:0] x, y, w, h, dx, dy, nx, ny;
        res_t r;
        x = $signed(c.bx);
        y = $signed(c.by);
        w = {41'd0, c.bw};
        h = {41'd0, c.bh};
        if (c.op == asbc_pkg::OP_WRITE) begin
            t_x[c.slot] = x;
            t_y[c.slot] = y;
            t_w[c.slot] = w;
            t_h[c.slot] = h;
            t_solid[c.slot] = c.solid;
            return;
        end
        dx = $signed(c.sx);
        dy = $signed(c.sy);
        r = '0;
        x = wrap24(x + dx);
        nx = x;
        foreach (written_slots[k]) begin
            int i;
            i = written_slots[k];
            if (overlaps(i, x, y, w, h)) begin
                if (dx > 0) begin
                    nx = wrap24(t_x[i] - w);
                    r.stop_x = 1'b1;
                end else if (dx < 0) begin
                    nx = wrap24(t_x[i] + t_w[i]);
                    r.stop_x = 1'b1;
                end
            end
        end
        x = nx;
        y = wrap24(y + dy);
        ny = y;
        foreach (written_slots[k]) begin
            int i;
            i = written_slots[k];
            if (overlaps(i, x, y, w, h)) begin
                if (dy > 0) begin
                    ny = wrap24(t_y[i] - h);
                    r.stop_y = 1'b1;
                end else if (dy < 0) begin
                    ny = wrap24(t_y[i] + t_h[i]);
                    r.stop_y = 1'b1;
                end
            end
        end
        r.nx = x[23:0];
        r.ny = ny[23:0];
        expected_moves.insert(expected_moves.size(), r);
    endtask

    // keeps the list of touched slots sorted so scans run in slot order
    task automatic note_slot(input int s);
        int pos;
        foreach (written_slots[k]) if (written_slots[k] == s) return;
        pos = 0;
        while (pos < written_slots.size() && written_slots[pos] < s) pos++;
        written_slots.insert(pos, s);
    endtask

    function automatic cmd_t rand_cmd(input bit op);
        cmd_t c;
        c.op = op;
        c.slot = 12'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) c.slot = 12'($urandom);
        c.bx = 24'($signed($urandom_range(0, 8000)) - 4000);
        c.by = 24'($signed($urandom_range(0, 8000)) - 4000);
        c.bw = 23'($urandom_range(0, 2048));
        c.bh = 23'($urandom_range(0, 2048));
        c.solid = ($urandom_range(0, 3) != 0);
        c.sx = 17'($signed($urandom_range(0, 1024)) - 512);
        c.sy = 17'($signed($urandom_range(0, 1024)) - 512);
        if ($urandom_range(0, 9) == 0) begin
            c.bx = 24'($urandom);
            c.by = 24'($urandom);
            c.bw = 23'($urandom);
            c.bh = 23'($urandom);
            c.sx = 17'($urandom);
            c.sy = 17'($urandom);
        end
        if ($urandom_range(0, 7) == 0) c.sx = '0;
        if ($urandom_range(0, 7) == 0) c.sy = '0;
        return c;
    endfunction

    initial begin
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_cmd(pending_cmds.pop_front());
            end
            if ((!s_tvalid || s_tready) || !s_tvalid) begin
                if (s_tvalid && !s_tready) begin
                    // hold current transfer
                end else if (pending_cmds.size() != 0 &&
                             $urandom_range(1, 100) > send_idle_pct) begin
                    cmd_t c;
                    c = pending_cmds[0];
                    s_tvalid <= 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= {3'b000, c.sy, c.sx, c.solid, c.bh, c.bw, c.by, c.bx, c.slot};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            res_t e;
            if (expected_moves.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                errors++;
            end else begin
                e = expected_moves.pop_front();
                if (m_tdata[23:0] !== e.nx) begin
                    $error("new_x expected %h actual %h", e.nx, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[47:24] !== e.ny) begin
                    $error("new_y expected %h actual %h", e.ny, m_tdata[47:24]);
                    errors++;
                end
                if (m_tdata[48] !== e.stop_x) begin
                    $error("stop_x expected %b actual %b", e.stop_x, m_tdata[48]);
                    errors++;
                end
                if (m_tdata[49] !== e.stop_y) begin
                    $error("stop_y expected %b actual %b", e.stop_y, m_tdata[49]);
                    errors++;
                end
            end
        end
    end

    task automatic queue_cmd(input cmd_t c);
        if (c.op == asbc_pkg::OP_WRITE) note_slot(c.slot);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_moves.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        cmd_t c;
        foreach (t_solid[i]) begin
            t_solid[i] = 1'b0;
            t_x[i] = 0; t_y[i] = 0; t_w[i] = 0; t_h[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a wall on the right and a floor, then moves into them
        c = '0;
        c.op = asbc_pkg::OP_WRITE; c.slot = 3; c.bx = 1000; c.by = -500; c.bw = 256;
        c.bh = 2000; c.solid = 1'b1; queue_cmd(c);
        c.slot = 7; c.bx = -2000; c.by = 800; c.bw = 4000; c.bh = 256; queue_cmd(c);
        c.slot = 12; c.bx = 1100; c.bw = 100; c.by = -500; c.bh = 3000; queue_cmd(c);
        c.slot = 4095; c.bx = 24'h800000; c.by = 24'h7fffff; c.bw = 23'h7fffff;
        c.bh = 23'h7fffff; c.solid = 1'b0; c.sx = 17'h10000; c.sy = 17'h0ffff; queue_cmd(c);
        c = '0; c.op = asbc_pkg::OP_MOVE; c.bx = 700; c.by = 0; c.bw = 256; c.bh = 256;
        c.sx = 200; c.sy = 700; c.slot = 12'hfff; c.solid = 1'b1; queue_cmd(c);
        c.bx = 1400; c.sx = -300; c.sy = -100; queue_cmd(c);
        c.bx = 900; c.sx = 0; c.sy = 0; queue_cmd(c);
        c.bw = 0; c.bh = 0; c.sx = 17'h0ffff; c.sy = 17'h10000; queue_cmd(c);
        c.bx = 24'h7fffff; c.by = 24'h800000; c.bw = 23'h7fffff; c.bh = 23'h7fffff;
        c.sx = 17'h0ffff; c.sy = 17'h10000; queue_cmd(c);
        c.bx = 24'h800000; c.by = 24'h7fffff; c.sx = 17'h10000; c.sy = 17'h0ffff;
        queue_cmd(c);
        c.bx = 1000; c.by = 700; c.bw = 256; c.bh = 256; c.sx = 1; c.sy = 1; queue_cmd(c);
        // clear a tile and retry
        c = '0; c.op = asbc_pkg::OP_WRITE; c.slot = 12; queue_cmd(c);
        c.op = asbc_pkg::OP_MOVE; c.bx = 1400; c.by = 0; c.bw = 256; c.bh = 256; c.sx = -300;
        c.sy = -100; queue_cmd(c);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 20 : 0;
            for (int n = 0; n < 33; n++) begin
                c = rand_cmd($urandom_range(0, 2) != 0);
                queue_cmd(c);
            end
            wait_drained();
        end
        repeat (20000) @(posedge aclk);
        if (errors == 0 && expected_moves.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/asbc_pkg.sv
sv/asbc_cell.sv
sv/axis_separated_box_collision.sv
dv/tb.sv
